[rtl/seu_pkg.sv]
package seu_pkg;

   localparam int CP_W      = 21;
   localparam int BYTE_W    = 8;
   localparam int MAX_BYTES = 4;
   localparam int IDX_W     = $clog2(MAX_BYTES);

   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam cp_type   CP_BS    = 21'h00008;
   localparam cp_type   CP_TAB   = 21'h00009;
   localparam cp_type   CP_LF    = 21'h0000A;
   localparam cp_type   CP_VT    = 21'h0000B;
   localparam cp_type   CP_FF    = 21'h0000C;
   localparam cp_type   CP_CR    = 21'h0000D;
   localparam cp_type   CP_QUOTE = 21'h00022;
   localparam cp_type   CP_BSL   = 21'h0005C;
   localparam cp_type   CP_DEL   = 21'h0007F;
   localparam cp_type   CP_SPACE = 21'h00020;
   localparam cp_type   CP_2BYTE = 21'h00080;
   localparam cp_type   CP_3BYTE = 21'h00800;
   localparam cp_type   CP_4BYTE = 21'h10000;

   localparam byte_type CH_BSL   = 8'h5C;
   localparam byte_type CH_QUOTE = 8'h22;
   localparam byte_type CH_ZERO  = 8'h30;
   localparam byte_type CH_B     = 8'h62;
   localparam byte_type CH_F     = 8'h66;
   localparam byte_type CH_N     = 8'h6E;
   localparam byte_type CH_R     = 8'h72;
   localparam byte_type CH_T     = 8'h74;
   localparam byte_type CH_V     = 8'h76;

   localparam byte_type LEAD2    = 8'hC0;
   localparam byte_type LEAD3    = 8'hE0;
   localparam byte_type LEAD4    = 8'hF0;
   localparam byte_type CONT     = 8'h80;

   localparam logic     ESCAPE_MODE_RESET = 1'b1;

endpackage

[rtl/seu_req_if.sv]
interface seu_req_if;
   logic                   valid;
   logic                   ready;
   logic [seu_pkg::CP_W-1:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface

[rtl/seu_rsp_if.sv]
interface seu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [seu_pkg::BYTE_W-1:0] out_byte;
   logic                       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[rtl/string_escape_utf8_encoder.sv]
// The first byte of an item is offered from the byte buffer after the item has passed
// through the input register, and not before the last byte of the previous item is taken.
// Each item produces N (1 to 4) bytes; the input register can accept the next item
// while the byte buffer is still sending the bytes of the previous one.
// Reset (synchronous, active high) empties the input register and the byte buffer
// and sets escape_mode to 1.
module string_escape_utf8_encoder (
   input  logic         clock,
   input  logic         reset,
   seu_req_if.sink      req,
   seu_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic         csr_wdata
);

   logic                 escape_mode_ff;
   logic                 in_valid_ff, in_valid_in;
   seu_pkg::cp_type      cp_ff, cp_in;
   logic                 buf_valid_ff, buf_valid_in;
   seu_pkg::byte_type    bytes_ff [seu_pkg::MAX_BYTES];
   seu_pkg::byte_type    bytes_in [seu_pkg::MAX_BYTES];
   seu_pkg::idx_type     idx_ff, idx_in;
   seu_pkg::idx_type     last_ff, last_in;

   seu_pkg::byte_type    enc_bytes [seu_pkg::MAX_BYTES];
   seu_pkg::idx_type     enc_last;
   seu_pkg::byte_type    letter;
   logic                 is_last;
   logic                 buf_free;
   logic                 load;

   // Encoder: the byte sequence for the code point in the input register.
   always_comb begin
      letter = '0;
      if (escape_mode_ff) begin
         case (cp_ff)
            seu_pkg::CP_BS:    letter = seu_pkg::CH_B;
            seu_pkg::CP_FF:    letter = seu_pkg::CH_F;
            seu_pkg::CP_LF:    letter = seu_pkg::CH_N;
            seu_pkg::CP_CR:    letter = seu_pkg::CH_R;
            seu_pkg::CP_TAB:   letter = seu_pkg::CH_T;
            seu_pkg::CP_VT:    letter = seu_pkg::CH_V;
            seu_pkg::CP_BSL:   letter = seu_pkg::CH_BSL;
            seu_pkg::CP_QUOTE: letter = seu_pkg::CH_QUOTE;
            default:           letter = '0;
         endcase
      end

      for (int i = 0; i < seu_pkg::MAX_BYTES; i++) begin
         enc_bytes[i] = '0;
      end
      enc_last = '0;

      if (!escape_mode_ff && (cp_ff == seu_pkg::CP_TAB || cp_ff == seu_pkg::CP_LF)) begin
         enc_bytes[0] = cp_ff[seu_pkg::BYTE_W-1:0];
      end else if (letter != '0) begin
         enc_bytes[0] = seu_pkg::CH_BSL;
         enc_bytes[1] = letter;
         enc_last     = seu_pkg::idx_type'(1);
      end else if (cp_ff < seu_pkg::CP_SPACE || cp_ff == seu_pkg::CP_DEL) begin
         enc_bytes[0] = seu_pkg::CH_BSL;
         enc_bytes[1] = seu_pkg::CH_ZERO | {5'd0, cp_ff[8:6]};
         enc_bytes[2] = seu_pkg::CH_ZERO | {5'd0, cp_ff[5:3]};
         enc_bytes[3] = seu_pkg::CH_ZERO | {5'd0, cp_ff[2:0]};
         enc_last     = seu_pkg::idx_type'(3);
      end else if (cp_ff < seu_pkg::CP_2BYTE) begin
         enc_bytes[0] = cp_ff[seu_pkg::BYTE_W-1:0];
      end else if (cp_ff < seu_pkg::CP_3BYTE) begin
         enc_bytes[0] = seu_pkg::LEAD2 | {3'd0, cp_ff[10:6]};
         enc_bytes[1] = seu_pkg::CONT | {2'd0, cp_ff[5:0]};
         enc_last     = seu_pkg::idx_type'(1);
      end else if (cp_ff < seu_pkg::CP_4BYTE) begin
         enc_bytes[0] = seu_pkg::LEAD3 | {4'd0, cp_ff[15:12]};
         enc_bytes[1] = seu_pkg::CONT | {2'd0, cp_ff[11:6]};
         enc_bytes[2] = seu_pkg::CONT | {2'd0, cp_ff[5:0]};
         enc_last     = seu_pkg::idx_type'(2);
      end else begin
         enc_bytes[0] = seu_pkg::LEAD4 | {5'd0, cp_ff[20:18]};
         enc_bytes[1] = seu_pkg::CONT | {2'd0, cp_ff[17:12]};
         enc_bytes[2] = seu_pkg::CONT | {2'd0, cp_ff[11:6]};
         enc_bytes[3] = seu_pkg::CONT | {2'd0, cp_ff[5:0]};
         enc_last     = seu_pkg::idx_type'(3);
      end
   end

   assign is_last   = (idx_ff == last_ff);
   assign buf_free  = !buf_valid_ff || (rsp.ready && is_last);
   assign load      = in_valid_ff && buf_free;
   assign req.ready = !in_valid_ff || buf_free;

   assign rsp.valid     = buf_valid_ff;
   assign rsp.out_byte  = bytes_ff[idx_ff];
   assign rsp.last_byte = is_last;

   always_comb begin
      in_valid_in  = in_valid_ff;
      cp_in        = cp_ff;
      buf_valid_in = buf_valid_ff;
      bytes_in     = bytes_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;

      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         cp_in       = req.code_point;
      end

      if (buf_valid_ff && rsp.ready) begin
         if (is_last) begin
            buf_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + seu_pkg::idx_type'(1);
         end
      end
      if (load) begin
         buf_valid_in = 1'b1;
         bytes_in     = enc_bytes;
         idx_in       = '0;
         last_in      = enc_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_mode_ff <= seu_pkg::ESCAPE_MODE_RESET;
         in_valid_ff    <= 1'b0;
         buf_valid_ff   <= 1'b0;
         idx_ff         <= '0;
      end else begin
         if (csr_we) begin
            escape_mode_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff    <= cp_in;
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> idx_ff <= last_ff)
      else $error("byte index beyond the last byte of the item");

   a_load_starts_at_first: assert property (@(posedge clock) disable iff (reset)
      load |=> (buf_valid_ff && idx_ff == '0 && !rsp.last_byte == (last_ff != '0)))
      else $error("new item does not start at its first byte");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp.valid && escape_mode_ff))
      else $error("block not empty after reset");

endmodule
